/* rtl/abpe_pkg.sv */
// ----------------------------------------------------------------------------
// abpe_pkg
// shared constants, types and state codes of the battery level estimator
// ----------------------------------------------------------------------------
package abpe_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int COUNT_BITS   = 8;
  localparam int POS_BITS     = 9;
  localparam int SUM_BITS     = 20;
  localparam int MV_BITS      = 12;
  localparam int PCT_BITS     = 7;
  localparam int MV_NUM       = 450;
  localparam int MV_SHIFT     = 9;
  localparam int MV_HALF      = 1024 / 2 / 2;
  localparam int MV_LIMIT     = 4095;
  localparam int PCT_SCALE    = 100;
  localparam int PCT_FULL     = 100;
  localparam int POS_MAX      = 511;
  localparam int DIV_N_BITS   = 20;
  localparam int DIV_D_BITS   = 12;
  localparam int DIV_CNT_BITS = 5;

  // register map, index = byte address / 4
  typedef enum logic [1:0] {
    REG_DISCARD = 2'd0,
    REG_KEEP    = 2'd1,
    REG_FULL    = 2'd2,
    REG_EMPTY   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MV,
    ST_PCT,
    ST_PWAIT,
    ST_OUT
  } scale_state_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] discard;
    logic [COUNT_BITS-1:0] keep;
    logic [MV_BITS-1:0]    full_mv;
    logic [MV_BITS-1:0]    empty_mv;
  } cfg_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]   sum;
    logic [COUNT_BITS-1:0] count;
  } job_t;

  typedef struct packed {
    logic [PCT_BITS-1:0] percent;
    logic [MV_BITS-1:0]  millivolts;
    logic                no_valid;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_N_BITS-1:0] dividend;
    logic [DIV_D_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIV_N_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/abpe_serial_div.sv */
// ----------------------------------------------------------------------------
// abpe_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module abpe_serial_div (
  input  logic               clk,
  input  logic               rst,
  input  abpe_pkg::div_req_t req,
  output abpe_pkg::div_rsp_t rsp
);
  import abpe_pkg::*;

  logic                    busy;
  logic                    done;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIV_N_BITS-1:0]   quo;
  logic [DIV_D_BITS-1:0]   rem;
  logic [DIV_D_BITS-1:0]   dsr;
  logic [DIV_D_BITS:0]     trial;
  logic [DIV_D_BITS:0]     diff;
  logic                    fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, quo[DIV_N_BITS-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(DIV_N_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_N_BITS-2:0], fits};
      rem <= fits ? diff[DIV_D_BITS-1:0] : trial[DIV_D_BITS-1:0];
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

`ifndef SYNTH
  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");
  a_no_restart : assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");
  a_quo_holds : assert property (@(posedge clk) disable iff (rst)
    (!busy && !req.start) |=> $stable(quo))
    else $error("quotient changed while divider idle");
`endif

endmodule

/* rtl/abpe_accum.sv */
// ----------------------------------------------------------------------------
// abpe_accum
// measurement position tracking, nonzero sample sum and count
// ----------------------------------------------------------------------------
module abpe_accum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic [abpe_pkg::SAMPLE_BITS-1:0]  sample,
  input  logic                              restart,
  input  abpe_pkg::cfg_t                    cfg,
  output logic                              job_valid,
  output abpe_pkg::job_t                    job
);
  import abpe_pkg::*;

  logic [POS_BITS-1:0]   position;
  logic [SUM_BITS-1:0]   running_sum;
  logic [COUNT_BITS-1:0] valid_count;

  logic [POS_BITS-1:0]   pos_cur;
  logic [SUM_BITS-1:0]   sum_cur;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [POS_BITS-1:0]   last;
  logic [POS_BITS-1:0]   first;
  logic                  in_window;
  logic                  add_it;
  logic                  is_last;
  logic [SUM_BITS-1:0]   sum_next;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [POS_BITS-1:0]   pos_next;

  always_comb begin
    pos_cur   = restart ? '0 : position;
    sum_cur   = restart ? '0 : running_sum;
    cnt_cur   = restart ? '0 : valid_count;
    first     = {1'b0, cfg.discard};
    last      = first + {1'b0, cfg.keep};
    in_window = (cfg.keep != '0) && (pos_cur >= first) && (pos_cur < last);
    add_it    = in_window && (sample != '0);
    is_last   = in_window && (pos_cur == last - 1'b1);
    sum_next  = add_it ? sum_cur + SUM_BITS'(sample) : sum_cur;
    cnt_next  = add_it ? cnt_cur + 1'b1 : cnt_cur;
    pos_next  = (pos_cur < POS_BITS'(POS_MAX)) ? pos_cur + 1'b1 : pos_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      running_sum <= '0;
      valid_count <= '0;
    end else if (take) begin
      position    <= pos_next;
      running_sum <= sum_next;
      valid_count <= cnt_next;
    end
  end

  assign job_valid = take && is_last;
  assign job.sum   = sum_next;
  assign job.count = cnt_next;

endmodule

/* rtl/abpe_scale.sv */
// ----------------------------------------------------------------------------
// abpe_scale
// mean, millivolt scaling and percentage sequencer over the serial divider
// ----------------------------------------------------------------------------
module abpe_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  abpe_pkg::job_t     job,
  input  abpe_pkg::cfg_t     cfg,
  input  logic               out_free,
  input  abpe_pkg::div_rsp_t div_rsp,
  output abpe_pkg::div_req_t div_req,
  output logic               busy,
  output logic               res_valid,
  output abpe_pkg::result_t  res
);
  import abpe_pkg::*;

  scale_state_t state, state_next;

  logic [MV_BITS-1:0]    mean;
  logic [MV_BITS-1:0]    mv;
  logic [PCT_BITS-1:0]   pct;
  logic                  none;

  logic [MV_BITS+MV_SHIFT:0]   mv_sum;
  logic [MV_BITS:0]            mv_wide;
  logic [MV_BITS-1:0]          mv_calc;
  logic [MV_BITS-1:0]          range;
  logic [MV_BITS-1:0]          over;
  logic [DIV_N_BITS-1:0]       pct_num;
  logic                        at_full;
  logic                        at_empty;

  // millivolts = (mean * 450 + 256) / 512, saturated
  always_comb begin
    mv_sum  = (MV_BITS+MV_SHIFT+1)'(mean) * (MV_BITS+MV_SHIFT+1)'(MV_NUM)
              + (MV_BITS+MV_SHIFT+1)'(MV_HALF);
    mv_wide = mv_sum[MV_BITS+MV_SHIFT:MV_SHIFT];
    mv_calc = (mv_wide > (MV_BITS+1)'(MV_LIMIT)) ? MV_BITS'(MV_LIMIT)
                                                 : mv_wide[MV_BITS-1:0];
  end

  // linear percentage numerator, rounded by half the range
  always_comb begin
    range    = cfg.full_mv - cfg.empty_mv;
    over     = mv - cfg.empty_mv;
    pct_num  = DIV_N_BITS'(over) * DIV_N_BITS'(PCT_SCALE)
               + DIV_N_BITS'(range >> 1);
    at_full  = mv >= cfg.full_mv;
    at_empty = mv <= cfg.empty_mv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = job.sum;
    div_req.divisor  = DIV_D_BITS'(job.count);
    res_valid        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          if (job.count == '0) begin
            state_next = ST_OUT;
          end else begin
            div_req.start = 1'b1;
            state_next    = ST_MEAN;
          end
        end
      end
      ST_MEAN: begin
        if (div_rsp.done) state_next = ST_MV;
      end
      ST_MV: begin
        state_next = ST_PCT;
      end
      ST_PCT: begin
        div_req.dividend = pct_num;
        div_req.divisor  = range;
        if (at_full || at_empty) begin
          state_next = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_next    = ST_PWAIT;
        end
      end
      ST_PWAIT: begin
        if (div_rsp.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        res_valid = 1'b1;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          none <= (job.count == '0);
          mv   <= '0;
          pct  <= '0;
        end
      end
      ST_MEAN: begin
        if (div_rsp.done) mean <= div_rsp.quotient[MV_BITS-1:0];
      end
      ST_MV: begin
        mv <= mv_calc;
      end
      ST_PCT: begin
        if (at_full) begin
          pct <= PCT_BITS'(PCT_FULL);
        end else if (at_empty) begin
          pct <= '0;
        end
      end
      ST_PWAIT: begin
        if (div_rsp.done) pct <= div_rsp.quotient[PCT_BITS-1:0];
      end
      default: ;
    endcase
  end

  assign busy           = state != ST_IDLE;
  assign res.percent    = pct;
  assign res.millivolts = mv;
  assign res.no_valid   = none;

endmodule

/* rtl/adc_battery_percent_estimator_core.sv */
// flow: a beat that does not close a measurement is absorbed without a stall
// a closing beat runs through two serial divisions, the mean and then the percentage,
// only the mean division when the level is clamped, and none with no nonzero sample
// s_tready stays low until its result enters the output register, which holds
// it so the next beat can be taken while it waits
// reset: synchronous, active high; control and config registers return to their defaults, no sweep
// ----------------------------------------------------------------------------
// adc_battery_percent_estimator_core
// averaged adc battery level estimator with apb register port
// ----------------------------------------------------------------------------
module adc_battery_percent_estimator_core (
  input  logic        clk,
  input  logic        rst,
  // sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
  input  logic        s_tuser,   // [0] restart
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [6:0] percent, [18:7] millivolts, [23:19] zero
  output logic        m_tuser,   // [0] no_valid_samples
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import abpe_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     reg_wr;

  logic     take;
  logic     job_valid;
  job_t     job;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     scale_busy;
  logic     res_valid;
  result_t  res;
  logic     out_free;
  result_t  out_res;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.discard  <= COUNT_BITS'(5);
      cfg.keep     <= COUNT_BITS'(10);
      cfg.full_mv  <= MV_BITS'(380);
      cfg.empty_mv <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_DISCARD: cfg.discard  <= pwdata[COUNT_BITS-1:0];
        REG_KEEP:    cfg.keep     <= pwdata[COUNT_BITS-1:0];
        REG_FULL:    cfg.full_mv  <= pwdata[MV_BITS-1:0];
        REG_EMPTY:   cfg.empty_mv <= pwdata[MV_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DISCARD: prdata = 32'(cfg.discard);
      REG_KEEP:    prdata = 32'(cfg.keep);
      REG_FULL:    prdata = 32'(cfg.full_mv);
      REG_EMPTY:   prdata = 32'(cfg.empty_mv);
      default:     prdata = '0;
    endcase
  end

  // ---------------- input side ----------------
  // one measurement in post-processing at a time; accumulation itself never
  // stalls, so the input only stalls while post-processing runs and the
  // result waits for the output register
  assign s_tready = !scale_busy;
  assign take     = s_tvalid && s_tready;

  abpe_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .sample    (s_tdata[SAMPLE_BITS-1:0]),
    .restart   (s_tuser),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job)
  );

  // ---------------- post-processing ----------------
  abpe_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .cfg       (cfg),
    .out_free  (out_free),
    .div_rsp   (div_rsp),
    .div_req   (div_req),
    .busy      (scale_busy),
    .res_valid (res_valid),
    .res       (res)
  );

  // shared between the mean and the percentage division
  abpe_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------- output register ----------------
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) out_res <= res;
  end

  assign m_tdata = {5'b0, out_res.millivolts, out_res.percent};
  assign m_tuser = out_res.no_valid;

`ifndef SYNTH
  a_no_take_when_busy : assert property (@(posedge clk) disable iff (rst)
    scale_busy |-> !s_tready)
    else $error("sample beat taken during post-processing");
  a_percent_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.percent <= PCT_BITS'(PCT_FULL)))
    else $error("percent beyond full scale");
  a_empty_result_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.no_valid) |->
      (out_res.percent == '0 && out_res.millivolts == '0))
    else $error("no-valid result carries a level");
`endif

endmodule
